FILE: rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Types, token codes and small helper functions shared by the tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int MAX_NUMBER_CHARS_DEF = 32;
  localparam int MAX_TOK    = 4;   // tokens one byte can cause
  localparam int FIFO_DEPTH = 8;

  localparam logic [62:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;

  // token kinds
  localparam logic [5:0] K_END     = 6'd0;
  localparam logic [5:0] K_IDENT   = 6'd1;
  localparam logic [5:0] K_KW_BASE = 6'd2;
  localparam logic [5:0] K_INT     = 6'd8;
  localparam logic [5:0] K_FLOAT   = 6'd9;
  localparam logic [5:0] K_STRING  = 6'd10;
  localparam logic [5:0] K_COLON   = 6'd11;
  localparam logic [5:0] K_SEMI    = 6'd12;
  localparam logic [5:0] K_COMMA   = 6'd13;
  localparam logic [5:0] K_DOT     = 6'd14;
  localparam logic [5:0] K_LPAREN  = 6'd15;
  localparam logic [5:0] K_RPAREN  = 6'd16;
  localparam logic [5:0] K_LBRACE  = 6'd17;
  localparam logic [5:0] K_RBRACE  = 6'd18;
  localparam logic [5:0] K_LBRACK  = 6'd19;
  localparam logic [5:0] K_RBRACK  = 6'd20;
  localparam logic [5:0] K_PLUS    = 6'd21;
  localparam logic [5:0] K_MINUS   = 6'd22;
  localparam logic [5:0] K_STAR    = 6'd23;
  localparam logic [5:0] K_SLASH   = 6'd24;
  localparam logic [5:0] K_ASSIGN  = 6'd25;
  localparam logic [5:0] K_BANG    = 6'd27;
  localparam logic [5:0] K_GT      = 6'd29;
  localparam logic [5:0] K_LT      = 6'd31;
  localparam logic [5:0] K_UNTERM  = 6'd33;
  localparam logic [5:0] K_UNKNOWN = 6'd34;
  localparam logic [5:0] K_NONE    = 6'd0;

  // character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_INTDOT, M_FLOAT, M_STRING, M_SLASH,
    M_LINEC, M_BLOCK, M_BLOCKSTAR, M_EQ, M_BANG, M_GT, M_LT
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] first_line;
    logic [15:0] first_column;
    logic [31:0] start_offset;
    logic [15:0] lexeme_length;
    logic [62:0] token_value;
    logic        value_overflow;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [2:0]                  count;
    out_item_t [MAX_TOK-1:0]     items;
  } tok_batch_t;

  // keywords: string integer float set fn if, zero padded
  localparam logic [7:0] KW_TEXT [6][7] = '{
    '{8'h73, 8'h74, 8'h72, 8'h69, 8'h6E, 8'h67, 8'h00},
    '{8'h69, 8'h6E, 8'h74, 8'h65, 8'h67, 8'h65, 8'h72},
    '{8'h66, 8'h6C, 8'h6F, 8'h61, 8'h74, 8'h00, 8'h00},
    '{8'h73, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h66, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [15:0] KW_LEN [6] = '{16'd6, 16'd7, 16'd5, 16'd3, 16'd2, 16'd2};

  function automatic logic [15:0] inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122) || c == 8'd95;
  endfunction

  // drop keywords that cannot match with byte c at position len
  function automatic logic [5:0] mask_upd(input logic [5:0] m, input logic [15:0] len,
                                          input logic [7:0] c);
    logic [5:0] r;
    r = m;
    for (int k = 0; k < 6; k++) begin
      if (len >= KW_LEN[k] || KW_TEXT[k][len[2:0]] != c) r[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [5:0] ident_kind(input logic [5:0] m, input logic [15:0] len);
    logic [5:0] kind;
    kind = K_IDENT;
    for (int k = 0; k < 6; k++) begin
      if (m[k] && len == KW_LEN[k]) kind = K_KW_BASE + 6'(k);
    end
    return kind;
  endfunction

  function automatic logic [5:0] single_code(input logic [7:0] c);
    logic [5:0] r;
    unique case (c)
      8'h3A:   r = K_COLON;
      8'h3B:   r = K_SEMI;
      8'h2C:   r = K_COMMA;
      8'h2E:   r = K_DOT;
      8'h28:   r = K_LPAREN;
      8'h29:   r = K_RPAREN;
      8'h7B:   r = K_LBRACE;
      8'h7D:   r = K_RBRACE;
      8'h5B:   r = K_LBRACK;
      8'h5D:   r = K_RBRACK;
      8'h2B:   r = K_PLUS;
      8'h2D:   r = K_MINUS;
      8'h2A:   r = K_STAR;
      default: r = K_NONE;
    endcase
    return r;
  endfunction

  // one-character kind of a pending relational / assignment operator
  function automatic logic [5:0] op_kind(input lex_mode_t m);
    logic [5:0] r;
    unique case (m)
      M_EQ:    r = K_ASSIGN;
      M_BANG:  r = K_BANG;
      M_GT:    r = K_GT;
      default: r = K_LT;
    endcase
    return r;
  endfunction

  function automatic out_item_t mk_tok(input logic [5:0] kind, input logic [15:0] line,
                                       input logic [15:0] col, input logic [31:0] off,
                                       input logic [15:0] len, input logic [62:0] val,
                                       input logic ovf);
    out_item_t t;
    t.token_kind     = kind;
    t.first_line     = line;
    t.first_column   = col;
    t.start_offset   = off;
    t.lexeme_length  = len;
    t.token_value    = val;
    t.value_overflow = ovf;
    t.last_of_run    = 1'b0;
    return t;
  endfunction

endpackage

FILE: rtl/core/stt_core.sv
// ----------------------------------------------------------------------------
// stt_core
// Lexer state and the per-byte step: updates the scan state and builds the
// batch of tokens (up to four) that one byte causes.
// ----------------------------------------------------------------------------
module stt_core #(
  parameter int MAX_NUMBER_CHARS = stt_pkg::MAX_NUMBER_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  stt_pkg::in_item_t  in_data,
  output stt_pkg::tok_batch_t batch
);
  import stt_pkg::*;

  lex_mode_t   mode_r, mode_nxt;
  logic [15:0] cur_line_r, cur_line_nxt, cur_col_r, cur_col_nxt;
  logic [31:0] cur_off_r, cur_off_nxt;
  logic [15:0] tok_line_r, tok_line_nxt, tok_col_r, tok_col_nxt;
  logic [31:0] tok_off_r, tok_off_nxt;
  logic [15:0] tok_len_r, tok_len_nxt;
  logic [62:0] acc_r, acc_nxt;
  logic        sat_r, sat_nxt;
  logic [5:0]  kmask_r, kmask_nxt;
  logic [15:0] dot_col_r, dot_col_nxt;

  localparam logic [15:0] LONG_LEN = 16'(MAX_NUMBER_CHARS);

  // next state and token generation
  always_comb begin
    logic [7:0]  c;
    logic        fin;
    logic        go_idle;
    logic [2:0]  n;
    logic [66:0] s;
    logic [5:0]  code;
    lex_mode_t   m;
    logic [15:0] cl, cc, tl, tc, tlen, dc;
    logic [31:0] co, to;
    logic [62:0] acc;
    logic        sat;
    logic [5:0]  km;

    c = in_data.text_byte;
    fin = in_data.final_byte;
    go_idle = 1'b0;
    n = 3'd0;
    s = '0;
    code = K_NONE;
    m = mode_r;
    cl = cur_line_r; cc = cur_col_r; co = cur_off_r;
    tl = tok_line_r; tc = tok_col_r; to = tok_off_r; tlen = tok_len_r;
    acc = acc_r; sat = sat_r; km = kmask_r; dc = dot_col_r;
    batch = '0;

    unique case (m)
      M_IDENT: begin
        if (is_alpha(c) || is_numeral(c)) begin
          km = mask_upd(km, tlen, c);
          tlen = inc16(tlen);
        end else begin
          batch.items[n[1:0]] = mk_tok(ident_kind(km, tlen), tl, tc, to, tlen, '0, 1'b0);
          n = n + 3'd1;
          go_idle = 1'b1;
        end
      end
      M_INT: begin
        if (is_numeral(c)) begin
          s = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 67'(c - 8'd48);
          if (s > {4'b0, MAX63}) begin
            acc = MAX63;
            sat = 1'b1;
          end else begin
            acc = s[62:0];
          end
          tlen = inc16(tlen);
        end else if (c == CH_DOT) begin
          m = M_INTDOT;
          dc = cc;
        end else begin
          batch.items[n[1:0]] = mk_tok(K_INT, tl, tc, to, tlen, acc,
                                       sat | (tlen >= LONG_LEN));
          n = n + 3'd1;
          go_idle = 1'b1;
        end
      end
      M_INTDOT: begin
        if (is_numeral(c)) begin
          m = M_FLOAT;
          tlen = inc16(inc16(tlen));
        end else begin
          batch.items[n[1:0]] = mk_tok(K_INT, tl, tc, to, tlen, acc,
                                       sat | (tlen >= LONG_LEN));
          n = n + 3'd1;
          batch.items[n[1:0]] = mk_tok(K_DOT, tl, dc, co - 32'd1, 16'd1, '0, 1'b0);
          n = n + 3'd1;
          go_idle = 1'b1;
        end
      end
      M_FLOAT: begin
        if (is_numeral(c)) begin
          tlen = inc16(tlen);
        end else begin
          batch.items[n[1:0]] = mk_tok(K_FLOAT, tl, tc, to, tlen, '0, tlen >= LONG_LEN);
          n = n + 3'd1;
          go_idle = 1'b1;
        end
      end
      M_STRING: begin
        if (c == CH_QUOTE) begin
          batch.items[n[1:0]] = mk_tok(K_STRING, tl, tc, to, tlen, '0, 1'b0);
          n = n + 3'd1;
          m = M_IDLE;
        end else begin
          tlen = inc16(tlen);
        end
      end
      M_SLASH: begin
        if (c == CH_SLASH) m = M_LINEC;
        else if (c == CH_STAR) m = M_BLOCK;
        else begin
          batch.items[n[1:0]] = mk_tok(K_SLASH, tl, tc, to, tlen, '0, 1'b0);
          n = n + 3'd1;
          go_idle = 1'b1;
        end
      end
      M_LINEC: begin
        if (c == CH_LF) m = M_IDLE;
      end
      M_BLOCK: begin
        if (c == CH_STAR) m = M_BLOCKSTAR;
      end
      M_BLOCKSTAR: begin
        if (c == CH_SLASH) m = M_IDLE;
        else if (c != CH_STAR) m = M_BLOCK;
      end
      M_EQ, M_BANG, M_GT, M_LT: begin
        if (c == CH_EQ) begin
          tlen = 16'd2;
          batch.items[n[1:0]] = mk_tok(op_kind(m) + 6'd1, tl, tc, to, tlen, '0, 1'b0);
          n = n + 3'd1;
          m = M_IDLE;
        end else begin
          batch.items[n[1:0]] = mk_tok(op_kind(m), tl, tc, to, tlen, '0, 1'b0);
          n = n + 3'd1;
          go_idle = 1'b1;
        end
      end
      default: go_idle = 1'b1;  // idle, and unused codes
    endcase

    // byte not consumed by the pending token: scan it from idle
    if (go_idle) begin
      m = M_IDLE;
      if (is_blank(c)) begin
        m = M_IDLE;
      end else if (is_alpha(c)) begin
        m = M_IDENT;
        tl = cl; tc = cc; to = co;
        km = mask_upd(6'h3F, 16'd0, c);
        tlen = 16'd1;
      end else if (is_numeral(c)) begin
        m = M_INT;
        tl = cl; tc = cc; to = co;
        tlen = 16'd1;
        acc = 63'(c - 8'd48);
        sat = 1'b0;
      end else if (c == CH_QUOTE) begin
        m = M_STRING;
        tl = cl; tc = cc; to = co + 32'd1;
        tlen = 16'd0;
      end else if (c == CH_SLASH || c == CH_EQ || c == CH_BANG || c == CH_GT ||
                   c == CH_LT) begin
        tl = cl; tc = cc; to = co;
        tlen = 16'd1;
        if (c == CH_SLASH) m = M_SLASH;
        else if (c == CH_EQ) m = M_EQ;
        else if (c == CH_BANG) m = M_BANG;
        else if (c == CH_GT) m = M_GT;
        else m = M_LT;
      end else begin
        code = single_code(c);
        if (code != K_NONE)
          batch.items[n[1:0]] = mk_tok(code, cl, cc, co, 16'd1, '0, 1'b0);
        else
          batch.items[n[1:0]] = mk_tok(K_UNKNOWN, cl, cc, co, 16'd1, 63'(c), 1'b0);
        n = n + 3'd1;
      end
    end

    co = co + 32'd1;
    if (c == CH_LF) begin
      cl = inc16(cl);
      cc = 16'd1;
    end else begin
      cc = inc16(cc);
    end

    // final byte: close the pending token, then the end token (at most four)
    if (fin) begin
      unique case (m)
        M_IDENT: begin
          batch.items[n[1:0]] = mk_tok(ident_kind(km, tlen), tl, tc, to, tlen, '0, 1'b0);
          n = n + 3'd1;
        end
        M_INT, M_INTDOT: begin
          batch.items[n[1:0]] = mk_tok(K_INT, tl, tc, to, tlen, acc,
                                       sat | (tlen >= LONG_LEN));
          n = n + 3'd1;
          if (m == M_INTDOT) begin
            batch.items[n[1:0]] = mk_tok(K_DOT, tl, dc, co - 32'd1, 16'd1, '0, 1'b0);
            n = n + 3'd1;
          end
        end
        M_FLOAT: begin
          batch.items[n[1:0]] = mk_tok(K_FLOAT, tl, tc, to, tlen, '0, tlen >= LONG_LEN);
          n = n + 3'd1;
        end
        M_STRING: begin
          batch.items[n[1:0]] = mk_tok(K_UNTERM, tl, tc, to, tlen, '0, 1'b0);
          n = n + 3'd1;
        end
        M_SLASH: begin
          batch.items[n[1:0]] = mk_tok(K_SLASH, tl, tc, to, tlen, '0, 1'b0);
          n = n + 3'd1;
        end
        M_EQ, M_BANG, M_GT, M_LT: begin
          batch.items[n[1:0]] = mk_tok(op_kind(m), tl, tc, to, tlen, '0, 1'b0);
          n = n + 3'd1;
        end
        default: ;
      endcase
      if (n != 3'd4) begin
        batch.items[n[1:0]] = mk_tok(K_END, cl, cc, co, 16'd0, '0, 1'b0);
        n = n + 3'd1;
      end
      m = M_IDLE;
      cl = 16'd1; cc = 16'd1; co = '0;
      tl = 16'd1; tc = 16'd1; to = '0; tlen = '0;
      acc = '0; sat = 1'b0; km = 6'h3F; dc = 16'd1;
    end

    if (n != 3'd0) batch.items[2'(n - 3'd1)].last_of_run = 1'b1;
    batch.count = n;

    mode_nxt = m;
    cur_line_nxt = cl; cur_col_nxt = cc; cur_off_nxt = co;
    tok_line_nxt = tl; tok_col_nxt = tc; tok_off_nxt = to; tok_len_nxt = tlen;
    acc_nxt = acc; sat_nxt = sat; kmask_nxt = km; dot_col_nxt = dc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      cur_line_r <= 16'd1;
      cur_col_r  <= 16'd1;
      cur_off_r  <= '0;
      tok_line_r <= 16'd1;
      tok_col_r  <= 16'd1;
      tok_off_r  <= '0;
      tok_len_r  <= '0;
      acc_r      <= '0;
      sat_r      <= 1'b0;
      kmask_r    <= 6'h3F;
      dot_col_r  <= 16'd1;
    end else if (step_en) begin
      mode_r     <= mode_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      cur_off_r  <= cur_off_nxt;
      tok_line_r <= tok_line_nxt;
      tok_col_r  <= tok_col_nxt;
      tok_off_r  <= tok_off_nxt;
      tok_len_r  <= tok_len_nxt;
      acc_r      <= acc_nxt;
      sat_r      <= sat_nxt;
      kmask_r    <= kmask_nxt;
      dot_col_r  <= dot_col_nxt;
    end
  end

endmodule

FILE: rtl/core/stt_fifo.sv
// ----------------------------------------------------------------------------
// stt_fifo
// Token queue: takes a batch of up to four tokens per cycle while it has room
// for four, hands out one.
module stt_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  stt_pkg::tok_batch_t wr_batch,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output stt_pkg::out_item_t  out_data
);
  import stt_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  out_item_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wptr_r, rptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               rd;
  logic [CNT_W-1:0]   wr_n;

  assign space     = count_r <= CNT_W'(FIFO_DEPTH - MAX_TOK);
  assign out_valid = count_r != '0;
  assign out_data  = mem[rptr_r];
  assign rd        = out_valid && out_ready;
  assign wr_n      = wr_en ? CNT_W'(wr_batch.count) : '0;
  assign count_nxt = count_r + wr_n - CNT_W'(rd);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < MAX_TOK; k++) begin
        if (3'(k) < wr_batch.count) mem[wptr_r + PTR_W'(k)] <= wr_batch.items[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_r + PTR_W'(wr_n);
      rptr_r  <= rptr_r + PTR_W'(rd);
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("token queue over capacity");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> space)
    else $error("batch written without room");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd) |=> count_r == $past(count_r) + $past(wr_n))
    else $error("queue count lost a write");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && wr_batch.count != 3'd0) |-> wr_batch.items[2'(wr_batch.count - 3'd1)].last_of_run)
    else $error("batch without last marker");

endmodule

FILE: rtl/core/source_text_tokenizer_top.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// Streaming lexer: one source byte in per transfer, tokens out per transfer.
// ----------------------------------------------------------------------------
//  channel | ports                          | carries
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data    | text byte, final-byte flag
//  out     | out_valid, out_ready, out_data | one token with position/value
//
// One byte per cycle while in_ready is high: the lexer step runs from the input
// transfer into the state registers and the token queue. in_ready drops only
// when the 8-entry token queue has fewer than 4 free slots (a byte yields at
// most 4 tokens). A byte's tokens are written into the queue at its transfer.
// Synchronous active-low reset returns the lexer to idle at line 1, column 1.
module source_text_tokenizer_top #(
  parameter int MAX_NUMBER_CHARS = stt_pkg::MAX_NUMBER_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  stt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output stt_pkg::out_item_t out_data
);
  import stt_pkg::*;

  tok_batch_t batch;
  logic       step;

  assign step = in_valid && in_ready;

  stt_core #(
    .MAX_NUMBER_CHARS(MAX_NUMBER_CHARS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .in_data (in_data),
    .batch   (batch)
  );

  stt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (step),
    .wr_batch  (batch),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
